FILE: rtl/hbd_pkg.sv
// ----------------------------------------------------------------------------
// HDLC bit deframer package
// Shared types, constants and per-bit receive functions for the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package hbd_pkg;

  localparam int unsigned WordBits  = 8;
  localparam int unsigned CfgWidth  = 4;
  localparam int unsigned CntWidth  = $clog2(WordBits + 1);

  localparam logic [7:0]  FLAG_PATTERN = 8'h7E;
  localparam logic [7:0]  WINDOW_INIT  = 8'hFF;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_GOOD     = 16'h1D0F;
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [CfgWidth-1:0] BPW_RESET = CfgWidth'(WordBits);

  // Receive phase, one-hot
  typedef enum logic [2:0] {
    PH_HUNT  = 3'b001,
    PH_FLAGS = 3'b010,
    PH_DATA  = 3'b100
  } rx_phase_t;

  typedef struct packed {
    rx_phase_t   phase;
    logic [7:0]  window;
    logic [2:0]  ones;
    logic [2:0]  cnt;
    logic [15:0] crc;
  } rx_state_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       frame_end;
    logic       crc_error;
    logic       not_octet_aligned;
    logic       aborted;
  } rx_result_t;

  typedef struct packed {
    rx_state_t  st;
    rx_result_t res;
  } rx_step_t;

  // CRC-16-CCITT over one octet, MSB first
  function automatic logic [15:0] crc_octet(input logic [15:0] crc_in,
                                            input logic [7:0] octet);
    logic [15:0] c;
    c = crc_in ^ {octet, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  // Advance the receiver by one line bit
  function automatic rx_step_t rx_bit_step(input rx_state_t st, input logic b);
    rx_step_t r;
    r.st  = st;
    r.res = '0;
    if (st.phase != PH_FLAGS && st.phase != PH_DATA) begin
      // hunt for the opening flag
      r.st.window = {st.window[6:0], b};
      if (r.st.window == FLAG_PATTERN) begin
        r.st.phase  = PH_FLAGS;
        r.st.window = '0;
        r.st.cnt    = '0;
        r.st.ones   = '0;
      end
    end else begin
      if (st.phase == PH_FLAGS) begin
        r.st.crc = CRC_INIT;
      end
      priority if (!b && st.ones == 3'd5) begin
        // drop the stuffed zero
        r.st.phase = PH_DATA;
        r.st.ones  = '0;
      end else if (!b && st.ones == 3'd6) begin
        // flag: close the frame if one is open
        if (st.phase == PH_DATA) begin
          r.res.not_octet_aligned = (st.cnt != 3'd7);
          r.res.frame_end         = 1'b1;
          r.res.crc_error         = (st.crc != CRC_GOOD);
        end
        r.st.phase  = PH_FLAGS;
        r.st.cnt    = '0;
        r.st.ones   = '0;
        r.st.window = '0;
      end else if (b && st.ones == 3'd6) begin
        // abort: back to hunting, window and run left as they are
        r.res.frame_end = (st.phase == PH_DATA);
        r.res.aborted   = 1'b1;
        r.st.phase      = PH_HUNT;
      end else begin
        r.st.window = {st.window[6:0], b};
        r.st.ones   = b ? st.ones + 3'd1 : 3'd0;
        if (st.cnt == 3'd7) begin
          r.st.cnt            = '0;
          r.st.crc            = crc_octet(r.st.crc, r.st.window);
          r.res.byte_valid    = 1'b1;
          r.res.data_byte     = rev8(r.st.window);
          r.st.window         = '0;
          r.st.phase          = PH_DATA;
        end else begin
          r.st.cnt = st.cnt + 3'd1;
        end
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/hbd_word_walker.sv
// ----------------------------------------------------------------------------
// HDLC word walker
// Walks the valid bits of one received word, MSB first, through the
// per-bit receive step and merges the events of the word.
// ----------------------------------------------------------------------------
`default_nettype none

module hbd_word_walker (
  input  hbd_pkg::rx_state_t             st_in,
  input  logic [hbd_pkg::WordBits-1:0]   rx_bits,
  input  logic [hbd_pkg::CfgWidth-1:0]   bits_per_word,
  output hbd_pkg::rx_state_t             st_out,
  output hbd_pkg::rx_result_t            res_out
);

  logic [hbd_pkg::CntWidth-1:0] n_bits;

  // Saturate the bit count to the word width
  always_comb begin
    if (bits_per_word > hbd_pkg::CfgWidth'(hbd_pkg::WordBits)) begin
      n_bits = hbd_pkg::CntWidth'(hbd_pkg::WordBits);
    end else begin
      n_bits = hbd_pkg::CntWidth'(bits_per_word);
    end
  end

  // Step through bit positions from the top down; inactive positions pass
  always_comb begin
    hbd_pkg::rx_state_t  st;
    hbd_pkg::rx_result_t acc;
    hbd_pkg::rx_step_t   stp;
    st  = st_in;
    acc = '0;
    for (int k = hbd_pkg::WordBits - 1; k >= 0; k--) begin
      stp = hbd_pkg::rx_bit_step(st, rx_bits[k]);
      if (hbd_pkg::CntWidth'(k) < n_bits) begin
        st                    = stp.st;
        acc.frame_end         = acc.frame_end | stp.res.frame_end;
        acc.crc_error         = acc.crc_error | stp.res.crc_error;
        acc.not_octet_aligned = acc.not_octet_aligned | stp.res.not_octet_aligned;
        acc.aborted           = acc.aborted | stp.res.aborted;
        if (stp.res.byte_valid) begin
          acc.byte_valid = 1'b1;
          acc.data_byte  = stp.res.data_byte;
        end
      end
    end
    st_out  = st;
    res_out = acc;
  end

endmodule

`default_nettype wire

FILE: rtl/hdlc_bit_deframer_unit.sv
// ----------------------------------------------------------------------------
// HDLC bit deframer unit
// Receive-side HDLC deframer: flag hunt, zero destuffing, octet assembly,
// abort detection and CRC-16-CCITT residue check.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one item per word of line bits; the low bits_per_word bits of
//            in_tdata are taken, highest bit first.
//   out_*  : exactly one result item per input item. out_tdata carries the
//            completed octet (first received bit in the LSB, zero if none),
//            out_tlast marks a frame closed by a flag or abort, out_tuser
//            carries byte_valid, crc_error, not_octet_aligned and aborted.
//   cfg_*  : writes bits_per_word (0..8, larger values act as 8). Write it
//            only while no item is in flight. cfg_ready is always high.
// An accepted input passes through an input register, then the bit walk
// of up to eight line bits into the result register. Throughput is one
// item per cycle while out_tready is high; the per-word walk through
// the receiver state is the path that sets it.
// Reset clears the receiver to flag hunting, CRC to all ones and
// bits_per_word to 8. When out_tready is low a held result stays;
// one more item is taken into an empty input register, then in_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module hdlc_bit_deframer_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  // slave side
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] rx_bits
  // master side
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [7:0]                   out_tdata,  // [7:0] data_byte
  output logic                         out_tlast,  // frame_end
  output logic [3:0]                   out_tuser,  // [0] byte_valid, [1] crc_error,
                                                   // [2] not_octet_aligned, [3] aborted
  // configuration
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [hbd_pkg::CfgWidth-1:0] cfg_data    // bits_per_word
);

  logic [hbd_pkg::CfgWidth-1:0] bpw_r;
  logic [7:0]                   in_data_r;
  logic                         in_valid_r;
  logic                         out_valid_r;
  hbd_pkg::rx_state_t           state_r;
  hbd_pkg::rx_state_t           state_nxt;
  hbd_pkg::rx_result_t          res_nxt;
  hbd_pkg::rx_result_t          res_r;
  logic                         advance;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpw_r <= hbd_pkg::BPW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      bpw_r <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
    end
  end

  hbd_word_walker u_walker (
    .st_in         (state_r),
    .rx_bits       (in_data_r),
    .bits_per_word (bpw_r),
    .st_out        (state_nxt),
    .res_out       (res_nxt)
  );

  // Receiver state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase  <= hbd_pkg::PH_HUNT;
      state_r.window <= hbd_pkg::WINDOW_INIT;
      state_r.ones   <= '0;
      state_r.cnt    <= '0;
      state_r.crc    <= hbd_pkg::CRC_INIT;
      out_valid_r    <= 1'b0;
    end else begin
      if (advance) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r.data_byte;
  assign out_tlast  = res_r.frame_end;
  assign out_tuser  = {res_r.aborted, res_r.not_octet_aligned,
                       res_r.crc_error, res_r.byte_valid};

endmodule

`default_nettype wire

FILE: tb/hbd_frame_checker.sv
// ----------------------------------------------------------------------------
// HDLC deframer result checker
// Watches the line-word, result and bits_per_word channels of the deframer.
// It runs its own bit-serial receiver and compares each result item with
// the oldest predicted report, field by field.
// ----------------------------------------------------------------------------
module hbd_frame_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  input  logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] rx_bits
  input  logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic [7:0]                   out_tdata,  // [7:0] data_byte
  input  logic                         out_tlast,  // frame_end
  input  logic [3:0]                   out_tuser,  // [0] byte_valid, [1] crc_error,
                                                   // [2] not_octet_aligned, [3] aborted
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [hbd_pkg::CfgWidth-1:0] cfg_data,   // bits_per_word
  output int                           mismatches,
  output int                           reports_due
);
  timeunit 1ns;
  timeprecision 1ps;

  import hbd_pkg::*;

  // out_tuser bit positions
  localparam int U_BYTE_VALID = 0;
  localparam int U_CRC_ERROR  = 1;
  localparam int U_MISALIGNED = 2;
  localparam int U_ABORTED    = 3;

  localparam int SHOWN_MISMATCHES = 10;

  // Receiver copy
  rx_phase_t           rx_phase;
  logic [7:0]          window;
  logic [2:0]          ones_run;
  logic [2:0]          bit_count;
  logic [15:0]         fcs_reg;
  logic [CfgWidth-1:0] word_bits;

  rx_result_t report_q[$];

  // Fold one octet into the CRC register, first received bit first
  function automatic logic [15:0] fcs_add_octet(input logic [15:0] c,
                                                input logic [7:0] octet);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ octet[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  // Walk one line word through the receiver and build its report
  function automatic rx_result_t deframe_word(input logic [7:0] rx);
    rx_result_t r;
    logic       b;
    int         n;
    r = '0;
    n = (word_bits > WordBits) ? WordBits : int'(word_bits);
    for (int k = WordBits - 1; k >= 0; k--) begin
      if (k < n) begin
        b = rx[k];
        if (rx_phase != PH_FLAGS && rx_phase != PH_DATA) begin
          // hunt: slide the window until the opening flag lines up
          window = {window[6:0], b};
          if (window == FLAG_PATTERN) begin
            rx_phase  = PH_FLAGS;
            window    = '0;
            bit_count = '0;
            ones_run  = '0;
          end
        end else begin
          if (rx_phase == PH_FLAGS) begin
            fcs_reg = CRC_INIT;
          end
          if (!b && ones_run == 3'd5) begin
            // drop the stuffed zero
            rx_phase = PH_DATA;
            ones_run = '0;
          end else if (!b && ones_run == 3'd6) begin
            // closing or shared flag
            if (rx_phase == PH_DATA) begin
              r.frame_end = 1'b1;
              if (bit_count != 3'd7) r.not_octet_aligned = 1'b1;
              if (fcs_reg != CRC_GOOD) r.crc_error = 1'b1;
            end
            rx_phase  = PH_FLAGS;
            bit_count = '0;
            ones_run  = '0;
            window    = '0;
          end else if (b && ones_run == 3'd6) begin
            // abort keeps window and run count
            if (rx_phase == PH_DATA) r.frame_end = 1'b1;
            r.aborted = 1'b1;
            rx_phase  = PH_HUNT;
          end else begin
            window   = {window[6:0], b};
            ones_run = b ? ones_run + 3'd1 : 3'd0;
            if (bit_count == 3'd7) begin
              bit_count    = '0;
              fcs_reg      = fcs_add_octet(fcs_reg, window);
              r.byte_valid = 1'b1;
              for (int i = 0; i < 8; i++) r.data_byte[i] = window[7-i];
              window   = '0;
              rx_phase = PH_DATA;
            end else begin
              bit_count = bit_count + 3'd1;
            end
          end
        end
      end
    end
    return r;
  endfunction

  // Track config, check results, queue predictions
  always @(posedge clk) begin
    rx_result_t want;
    logic [3:0] want_user;
    logic       bad;
    if (!rst_n) begin
      rx_phase    = PH_HUNT;
      window      = WINDOW_INIT;
      ones_run    = '0;
      bit_count   = '0;
      fcs_reg     = CRC_INIT;
      word_bits   = BPW_RESET;
      mismatches  = 0;
      report_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        word_bits = cfg_data;
      end
      if (out_tvalid && out_tready) begin
        if (report_q.size() == 0) begin
          if (mismatches < SHOWN_MISMATCHES) begin
            $display("%0t: unexpected result octet %h end %b user %b",
                     $time, out_tdata, out_tlast, out_tuser);
          end
          mismatches++;
        end else begin
          want = report_q.pop_front();
          want_user[U_BYTE_VALID] = want.byte_valid;
          want_user[U_CRC_ERROR]  = want.crc_error;
          want_user[U_MISALIGNED] = want.not_octet_aligned;
          want_user[U_ABORTED]    = want.aborted;
          bad = (out_tdata !== want.data_byte)
             || (out_tlast !== want.frame_end)
             || (out_tuser[U_BYTE_VALID] !== want.byte_valid)
             || (out_tuser[U_CRC_ERROR]  !== want.crc_error)
             || (out_tuser[U_MISALIGNED] !== want.not_octet_aligned)
             || (out_tuser[U_ABORTED]    !== want.aborted);
          if (bad) begin
            if (mismatches < SHOWN_MISMATCHES) begin
              $display("%0t: result mismatch: octet %h/%h end %b/%b user %b/%b (want/got)",
                       $time, want.data_byte, out_tdata, want.frame_end, out_tlast,
                       want_user, out_tuser);
            end
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        report_q.push_back(deframe_word(in_tdata));
      end
    end
    reports_due = report_q.size();
  end

endmodule

FILE: tb/hdlc_bit_deframer_unit_test.sv
// ----------------------------------------------------------------------------
// HDLC bit deframer unit test
// Builds HDLC line bit streams (flags, stuffed payloads with FCS, bad FCS,
// ragged tails, aborts, noise), chops them into words at several
// bits_per_word settings and feeds them with bursty traffic on both sides.
// A separate checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module hdlc_bit_deframer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hbd_pkg::*;

  typedef enum int {FR_GOOD, FR_BAD_FCS, FR_RAGGED, FR_ABORTED, FR_NOISE} frame_kind_t;
  typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_BURSTY} ready_mode_t;

  localparam int PHASE_WORDS   = 88;
  localparam int ZERO_BPW_WORDS = 20;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [7:0]          out_tdata;
  logic                out_tlast;
  logic [3:0]          out_tuser;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [CfgWidth-1:0] cfg_data   = BPW_RESET;

  int mismatches;
  int reports_due;

  // Line bits still to be sent, oldest first
  bit line_q[$];
  int tx_ones;
  int eff_bits;
  int burst_left;
  bit valid_held;

  ready_mode_t ready_mode = RDY_ALWAYS;
  int          mode_left  = 0;
  int          stall_left = 0;

  logic [CfgWidth-1:0] word_bits_plan [12] = '{1, 8, 0, 15, 3, 5, 9, 2, 7, 4, 6, 8};

  always #2 clk = ~clk;

  hdlc_bit_deframer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  hbd_frame_checker u_frame_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .reports_due (reports_due)
  );

  // Result-side backpressure: switch between steady, random and bursty stalls
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 2));
      mode_left  <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      RDY_ALWAYS: out_tready <= 1'b1;
      RDY_RANDOM: out_tready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_left != 0) begin
          out_tready <= 1'b0;
          stall_left <= stall_left - 1;
        end else begin
          out_tready <= 1'b1;
          if ($urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 20);
        end
      end
    endcase
  end

  // Present one word and hold it until taken; idle between bursts
  task automatic send_word(input logic [7:0] w);
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    valid_held = 1'b1;
    do @(posedge clk); while (!in_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      valid_held = 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 12);
    end
  endtask

  // Lower valid, wait for every result, then let the pipeline settle
  task automatic wait_drained(input int settle);
    if (valid_held) begin
      in_tvalid <= 1'b0;
      valid_held = 1'b0;
    end
    do @(posedge clk); while (reports_due != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_word_bits(input logic [CfgWidth-1:0] v);
    wait_drained(4);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    eff_bits = (v > WordBits) ? WordBits : int'(v);
  endtask

  // Append raw bits, highest first, without stuffing
  task automatic put_raw(input logic [15:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) line_q.push_back(v[i]);
  endtask

  task automatic put_flag();
    put_raw({8'h00, FLAG_PATTERN}, 8);
    tx_ones = 0;
  endtask

  // Append one payload bit, inserting a zero after five ones
  task automatic put_data_bit(input bit b);
    line_q.push_back(b);
    if (!b) begin
      tx_ones = 0;
    end else begin
      tx_ones++;
      if (tx_ones == 5) begin
        line_q.push_back(1'b0);
        tx_ones = 0;
      end
    end
  endtask

  // Append one frame; fill >= 0 fixes every payload octet
  task automatic put_frame(input frame_kind_t kind, input int len, input int fill);
    logic [15:0] fcs;
    logic [7:0]  octet;
    int          cut;
    logic        fb;
    if (kind == FR_NOISE) begin
      repeat ($urandom_range(1, 40)) line_q.push_back(bit'($urandom_range(0, 3) != 0));
      return;
    end
    put_flag();
    fcs = CRC_INIT;
    cut = (len == 0) ? 0 : $urandom_range(1, len);
    for (int j = 0; j < len; j++) begin
      if (kind == FR_ABORTED && j == cut) begin
        put_raw(16'hFFFF, $urandom_range(7, 12));
        return;
      end
      if (fill >= 0) begin
        octet = fill[7:0];
      end else begin
        case ($urandom_range(0, 7))
          0:       octet = 8'hFF;
          1:       octet = FLAG_PATTERN;
          2:       octet = 8'h7D;
          default: octet = 8'($urandom);
        endcase
      end
      for (int i = 7; i >= 0; i--) begin
        fb  = fcs[15] ^ octet[i];
        fcs = {fcs[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        put_data_bit(octet[i]);
      end
    end
    if (kind == FR_ABORTED) begin
      put_raw(16'hFFFF, $urandom_range(7, 12));
      return;
    end
    fcs = ~fcs;
    if (kind == FR_BAD_FCS) fcs[$urandom_range(0, 15)] ^= 1'b1;
    for (int i = 15; i >= 0; i--) put_data_bit(fcs[i]);
    if (kind == FR_RAGGED) begin
      repeat ($urandom_range(1, 7)) put_data_bit(bit'($urandom_range(0, 1)));
    end
    put_flag();
  endtask

  // Pack queued line bits into words, idle ones pad the last word
  task automatic flush_line();
    logic [7:0] w;
    while (line_q.size() != 0) begin
      w = 8'($urandom);
      for (int i = eff_bits - 1; i >= 0; i--) begin
        w[i] = (line_q.size() != 0) ? line_q.pop_front() : 1'b1;
      end
      send_word(w);
    end
  endtask

  // Stimulus and verdict
  initial begin
    frame_kind_t kind;
    tx_ones    = 0;
    burst_left = 0;
    valid_held = 1'b0;
    eff_bits   = WordBits;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes while hunting, stuffing, bad FCS, ragged
    // tail, abort between flags and abort inside a frame
    send_word(8'h00);
    send_word(8'hFF);
    put_frame(FR_GOOD, 2, 255);
    put_frame(FR_BAD_FCS, 1, -1);
    put_frame(FR_RAGGED, 1, -1);
    put_flag();
    put_raw(16'hFFFF, 8);
    put_frame(FR_ABORTED, 1, -1);
    flush_line();

    // Random: mostly well-formed frames at each word width
    foreach (word_bits_plan[p]) begin
      write_word_bits(word_bits_plan[p]);
      if (eff_bits == 0) begin
        repeat (ZERO_BPW_WORDS) send_word(8'($urandom));
      end else begin
        while (line_q.size() < PHASE_WORDS * eff_bits) begin
          case ($urandom_range(0, 9))
            6:       kind = FR_BAD_FCS;
            7:       kind = FR_RAGGED;
            8:       kind = FR_ABORTED;
            9:       kind = FR_NOISE;
            default: kind = FR_GOOD;
          endcase
          put_frame(kind, ($urandom_range(0, 11) == 0) ? 16 : $urandom_range(0, 6), -1);
        end
        flush_line();
      end
    end

    wait_drained(8);
    if (mismatches == 0 && reports_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hard stop: a correct run ends well before it, even with the longest stalls and gaps
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
